/* src/lfu_pkg.sv */
// shared types and constants for the lfu cache with lru tie break
// no dependencies
`timescale 1ns / 1ps
package lfu_pkg;
   localparam int IDX_W     = 10;  // covers up to 1024 entries
   localparam int KEY_W     = 32;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int STAMP_W   = 48;
   localparam int CAP_W     = 5;
   localparam int MAX_ENTRIES = 1024;
   localparam int CAP_RESET = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // slot commands
   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_TOUCH  = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_FILL   = 2'd3;

   // record passed from cell to cell during a scan
   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   hit_idx;
      logic [DATA_W-1:0]  hit_data;
      logic               free_have;
      logic [IDX_W-1:0]   free_idx;
      logic               vic_have;
      logic [COUNT_W-1:0] vic_count;
      logic [STAMP_W-1:0] vic_stamp;
      logic [IDX_W-1:0]   vic_idx;
   } carry_type;

   // write command broadcast to all cells
   typedef struct packed {
      logic [1:0]         op;
      logic [IDX_W-1:0]   idx;
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [STAMP_W-1:0] stamp;
   } cmd_type;
endpackage

/* src/lfu_req_if.sv */
// request and response channel interfaces
// no dependencies
`timescale 1ns / 1ps
interface lfu_req_if;
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [31:0]       key;
   logic signed [31:0]       value;
   modport source (output valid, func, key, value, input ready);
   modport sink   (input valid, func, key, value, output ready);
endinterface

interface lfu_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic signed [31:0]       read_value;
   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

/* src/lfu_cache_with_lru_tiebreak_core.sv */
// top level of the lfu cache: controller plus a row of slot cells
// depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_cell
`timescale 1ns / 1ps
// Key-value cache with least-frequently-used replacement and a least-recently-
// used tie break. Each slot is a cell in a row; a request starts a scan record
// at cell 0 that moves one cell per clock, picking up the first key match, the
// first free slot and the eviction candidate (lowest count, then oldest stamp,
// then lowest index). The result is offered on rsp once the scan record has
// passed the whole cell row; one request is in flight at a time, so a new
// request is not taken until the previous one has finished. The result
// sits in an output register, so the next request can be taken while the
// previous result waits. capacity is to be written over csr_we and
// csr_wdata while the block is idle; the block itself does not enforce
// this. Values above ENTRIES act as ENTRIES and zero turns puts into no-ops
// (gets still look up). No clearing pass is needed.
module lfu_cache_with_lru_tiebreak_core #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   lfu_req_if.sink                       req,
   lfu_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [lfu_pkg::CAP_W-1:0]     csr_wdata
);
   import lfu_pkg::*;

   localparam int CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int WW = IDX_W + 1;   // wide enough for capacity and occupancy compare

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [OW-1:0]       occ_ff, occ_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic                accept, finish;
   logic [WW-1:0]       cap_eff, occ_w;
   carry_type           chain [ENTRIES+1];
   cmd_type             cmd;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   // finish once the output register is free or being drained
   assign finish    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.read_value = rsp_data_ff;

   assign cap_eff = (WW'(cap_ff) > WW'(ENTRIES)) ? WW'(ENTRIES) : WW'(cap_ff);
   assign occ_w   = WW'(occ_ff);

   // scan record entering the row carries nothing
   assign chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell #(.CELL_IDX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .key_i   (key_ff),
         .carry_i (chain[g]),
         .carry_o (chain[g+1]),
         .cmd_i   (cmd)
      );
   end

   // state machine and commit decision
   always_comb begin
      carry_type r;
      r            = chain[ENTRIES];
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      occ_in       = occ_ff;
      stamp_in     = stamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      cmd.op       = OP_NONE;
      cmd.idx      = '0;
      cmd.key      = key_ff;
      cmd.data     = value_ff;
      cmd.stamp    = stamp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (!func_ff) begin
                  if (r.found) begin
                     cmd.op  = OP_TOUCH;
                     cmd.idx = r.hit_idx;
                  end
               end else if (cap_eff != '0) begin
                  if (r.found) begin
                     cmd.op  = OP_UPDATE;
                     cmd.idx = r.hit_idx;
                  end else if (occ_w < cap_eff) begin
                     cmd.op  = OP_FILL;
                     cmd.idx = r.free_idx;
                     occ_in  = occ_ff + OW'(1);
                  end else if (r.vic_have) begin
                     cmd.op  = OP_FILL;
                     cmd.idx = r.vic_idx;
                  end
               end
               if (cmd.op != OP_NONE) begin
                  stamp_in = stamp_ff + STAMP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_W'(CAP_RESET);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req.func;
         key_ff   <= req.key;
         value_ff <= req.value;
      end
      if (finish) begin
         rsp_hit_ff  <= chain[ENTRIES].found;
         rsp_data_ff <= (!func_ff && chain[ENTRIES].found) ? chain[ENTRIES].hit_data
                                                           : '0;
      end
   end
endmodule

/* src/lfu_cell.sv */
// one cache slot: holds an entry and folds it into the scan record
// depends on lfu_pkg
`timescale 1ns / 1ps
module lfu_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             key_i,
   input  lfu_pkg::carry_type      carry_i,
   output lfu_pkg::carry_type      carry_o,
   input  lfu_pkg::cmd_type        cmd_i
);
   import lfu_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic               valid_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [DATA_W-1:0]  data_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [STAMP_W-1:0] stamp_ff;
   carry_type          carry_ff, carry_in;
   logic               older;

   assign older = (count_ff < carry_i.vic_count) ||
                  ((count_ff == carry_i.vic_count) && (stamp_ff < carry_i.vic_stamp));

   always_comb begin
      carry_in = carry_i;
      if (valid_ff && !carry_i.found && key_ff == key_i) begin
         carry_in.found    = 1'b1;
         carry_in.hit_idx  = MY_IDX;
         carry_in.hit_data = data_ff;
      end
      if (!valid_ff && !carry_i.free_have) begin
         carry_in.free_have = 1'b1;
         carry_in.free_idx  = MY_IDX;
      end
      if (valid_ff && (!carry_i.vic_have || older)) begin
         carry_in.vic_have  = 1'b1;
         carry_in.vic_count = count_ff;
         carry_in.vic_stamp = stamp_ff;
         carry_in.vic_idx   = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign carry_o = carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd_i.idx == MY_IDX && cmd_i.op == OP_FILL) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.idx == MY_IDX) begin
         case (cmd_i.op)
            OP_FILL: begin
               key_ff   <= cmd_i.key;
               data_ff  <= cmd_i.data;
               count_ff <= COUNT_W'(1);
               stamp_ff <= cmd_i.stamp;
            end
            OP_TOUCH, OP_UPDATE: begin
               if (cmd_i.op == OP_UPDATE) begin
                  data_ff <= cmd_i.data;
               end
               if (count_ff != COUNT_MAX) begin
                  count_ff <= count_ff + COUNT_W'(1);
               end
               stamp_ff <= cmd_i.stamp;
            end
            default: ;
         endcase
      end
   end
endmodule
